// ===== rtl/cttr_pkg.sv =====
// Shared widths, the word carried down the pipeline, and saturation.
package cttr_pkg;

  localparam int DATA_W = 32;
  localparam int RAD_W  = 20;
  localparam int TILE_W = 16;
  localparam int DXT_W  = RAD_W + 1;
  localparam int DSQ_W  = 2 * RAD_W + 1;
  localparam int ROOT_W = RAD_W + 1;

  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic        [RAD_W-1:0]  r;
    logic signed [DXT_W-1:0]  dx;
    logic signed [DXT_W-1:0]  dy;
    logic                     cand;
  } carry_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return signed'(v[DATA_W-1:0]);
    end
  endfunction

endpackage

// ===== rtl/cttr_front.sv =====
// Front end: clamp to the tile, squared distance, hit candidate test.
module cttr_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [cttr_pkg::DATA_W-1:0]   px,
  input  logic signed [cttr_pkg::DATA_W-1:0]   py,
  input  logic signed [cttr_pkg::DATA_W-1:0]   vx,
  input  logic signed [cttr_pkg::DATA_W-1:0]   vy,
  input  logic        [cttr_pkg::RAD_W-1:0]    r,
  input  logic signed [cttr_pkg::TILE_W-1:0]   tx,
  input  logic signed [cttr_pkg::TILE_W-1:0]   ty,
  output logic                                 out_valid,
  output cttr_pkg::carry_t                     out_carry,
  output logic        [cttr_pkg::DSQ_W-1:0]    out_dsq
);

  localparam int DW_T = FRAC_BITS + cttr_pkg::TILE_W + 2;
  localparam int DW_D = cttr_pkg::DATA_W + 2;
  localparam int DW   = (DW_T > DW_D) ? DW_T : DW_D;
  localparam logic [63:0] EPS = ((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000;

  logic signed [DW-1:0] lox, hix, loy, hiy, pxw, pyw, cx, cy, dxw, dyw, adx, ady, rw;
  logic                 near;

  always_comb begin
    lox = {{(DW-cttr_pkg::TILE_W){tx[cttr_pkg::TILE_W-1]}}, tx} <<< FRAC_BITS;
    loy = {{(DW-cttr_pkg::TILE_W){ty[cttr_pkg::TILE_W-1]}}, ty} <<< FRAC_BITS;
    hix = lox + (DW'(1) << FRAC_BITS);
    hiy = loy + (DW'(1) << FRAC_BITS);
    pxw = {{(DW-cttr_pkg::DATA_W){px[cttr_pkg::DATA_W-1]}}, px};
    pyw = {{(DW-cttr_pkg::DATA_W){py[cttr_pkg::DATA_W-1]}}, py};
    rw  = {{(DW-cttr_pkg::RAD_W){1'b0}}, r};
    cx  = (pxw < lox) ? lox : ((pxw > hix) ? hix : pxw);
    cy  = (pyw < loy) ? loy : ((pyw > hiy) ? hiy : pyw);
    dxw = pxw - cx;
    dyw = pyw - cy;
    adx = dxw[DW-1] ? -dxw : dxw;
    ady = dyw[DW-1] ? -dyw : dyw;
    near = (adx < rw) && (ady < rw);
  end

  // stage A: clamp
  logic             a_valid;
  cttr_pkg::carry_t a_carry;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_carry.px   <= px;
    a_carry.py   <= py;
    a_carry.vx   <= vx;
    a_carry.vy   <= vy;
    a_carry.r    <= r;
    a_carry.dx   <= dxw[cttr_pkg::DXT_W-1:0];
    a_carry.dy   <= dyw[cttr_pkg::DXT_W-1:0];
    a_carry.cand <= near;
  end

  // stage B: squares
  logic signed [cttr_pkg::DXT_W-1:0] ndx, ndy;
  logic        [cttr_pkg::RAD_W-1:0] mdx, mdy;
  logic                              b_valid;
  cttr_pkg::carry_t                  b_carry;
  logic [2*cttr_pkg::RAD_W-1:0]      b_sqx, b_sqy, b_rsq;

  always_comb begin
    ndx = a_carry.dx[cttr_pkg::DXT_W-1] ? -a_carry.dx : a_carry.dx;
    ndy = a_carry.dy[cttr_pkg::DXT_W-1] ? -a_carry.dy : a_carry.dy;
    mdx = ndx[cttr_pkg::RAD_W-1:0];
    mdy = ndy[cttr_pkg::RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_carry <= a_carry;
    b_sqx   <= mdx * mdx;
    b_sqy   <= mdy * mdy;
    b_rsq   <= a_carry.r * a_carry.r;
  end

  // stage C: sum and compare against radius squared and epsilon
  logic [cttr_pkg::DSQ_W-1:0] dsq;
  cttr_pkg::carry_t           c_carry;

  always_comb begin
    dsq          = {1'b0, b_sqx} + {1'b0, b_sqy};
    c_carry      = b_carry;
    c_carry.cand = b_carry.cand && (dsq < {1'b0, b_rsq}) && (64'(dsq) > EPS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= b_valid;
    end
    out_carry <= c_carry;
    out_dsq   <= dsq;
  end

endmodule

// ===== rtl/cttr_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module cttr_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  cttr_pkg::carry_t                  in_carry,
  input  logic [cttr_pkg::DSQ_W-1:0]        in_dsq,
  output logic                              out_valid,
  output cttr_pkg::carry_t                  out_carry,
  output logic [cttr_pkg::ROOT_W-1:0]       out_root
);

  localparam int NS = cttr_pkg::ROOT_W;
  localparam int RW = cttr_pkg::DSQ_W + 1;

  logic                        vld_s   [NS+1];
  cttr_pkg::carry_t            carry_s [NS+1];
  logic [RW-1:0]               rem_s   [NS+1];
  logic [cttr_pkg::ROOT_W-1:0] root_s  [NS+1];

  assign vld_s[0]   = in_valid;
  assign carry_s[0] = in_carry;
  assign rem_s[0]   = {1'b0, in_dsq};
  assign root_s[0]  = '0;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int B = NS - 1 - k;
    logic [RW-1:0] trial;

    // (root + 2^B)^2 - root^2
    assign trial = ({{(RW-cttr_pkg::ROOT_W){1'b0}}, root_s[k]} << (B + 1))
                   | (RW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vld_s[k];
      end
      carry_s[k+1] <= carry_s[k];
      if (rem_s[k] >= trial) begin
        rem_s[k+1]  <= rem_s[k] - trial;
        root_s[k+1] <= root_s[k] | (cttr_pkg::ROOT_W'(1) << B);
      end else begin
        rem_s[k+1]  <= rem_s[k];
        root_s[k+1] <= root_s[k];
      end
    end
  end

  assign out_valid = vld_s[NS];
  assign out_carry = carry_s[NS];
  assign out_root  = root_s[NS];

endmodule

// ===== rtl/cttr_div.sv =====
// Pipelined rounded divide of dx and dy by the distance, one quotient bit per stage.
module cttr_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  cttr_pkg::carry_t                  in_carry,
  input  logic [cttr_pkg::ROOT_W-1:0]       in_root,
  output logic                              out_valid,
  output cttr_pkg::carry_t                  out_carry,
  output logic [cttr_pkg::ROOT_W-1:0]       out_dist,
  output logic signed [FRAC_BITS+1:0]       out_nx,
  output logic signed [FRAC_BITS+1:0]       out_ny
);

  localparam int QW = FRAC_BITS + 1;
  localparam int DN = cttr_pkg::ROOT_W;
  localparam int NW = cttr_pkg::DXT_W + FRAC_BITS + 1;

  logic [DN-1:0] den;
  logic signed [cttr_pkg::DXT_W-1:0] sdx, sdy;
  logic [NW-1:0] numx, numy;

  always_comb begin
    den  = (in_root == '0) ? DN'(1) : in_root;
    sdx  = in_carry.dx[cttr_pkg::DXT_W-1] ? -in_carry.dx : in_carry.dx;
    sdy  = in_carry.dy[cttr_pkg::DXT_W-1] ? -in_carry.dy : in_carry.dy;
    numx = ({1'b0, sdx, {FRAC_BITS{1'b0}}}) + NW'(den >> 1);
    numy = ({1'b0, sdy, {FRAC_BITS{1'b0}}}) + NW'(den >> 1);
  end

  logic             vld_s   [QW+1];
  cttr_pkg::carry_t carry_s [QW+1];
  logic [DN-1:0]    den_s   [QW+1];
  logic [DN-1:0]    remx_s  [QW+1];
  logic [DN-1:0]    remy_s  [QW+1];
  logic [QW-1:0]    lowx_s  [QW+1];
  logic [QW-1:0]    lowy_s  [QW+1];
  logic [QW-1:0]    qx_s    [QW+1];
  logic [QW-1:0]    qy_s    [QW+1];

  // entry: split numerator into leading remainder and bits to bring down
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else begin
      vld_s[0] <= in_valid;
    end
    carry_s[0] <= in_carry;
    den_s[0]   <= den;
    remx_s[0]  <= numx[NW-1:QW];
    remy_s[0]  <= numy[NW-1:QW];
    lowx_s[0]  <= numx[QW-1:0];
    lowy_s[0]  <= numy[QW-1:0];
    qx_s[0]    <= '0;
    qy_s[0]    <= '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DN:0] r2x, r2y, dd;
    logic        gex, gey;

    always_comb begin
      dd  = {1'b0, den_s[k]};
      r2x = {remx_s[k], lowx_s[k][QW-1]};
      r2y = {remy_s[k], lowy_s[k][QW-1]};
      gex = (r2x >= dd);
      gey = (r2y >= dd);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= vld_s[k];
      end
      carry_s[k+1] <= carry_s[k];
      den_s[k+1]   <= den_s[k];
      remx_s[k+1]  <= gex ? DN'(r2x - dd) : r2x[DN-1:0];
      remy_s[k+1]  <= gey ? DN'(r2y - dd) : r2y[DN-1:0];
      lowx_s[k+1]  <= lowx_s[k] << 1;
      lowy_s[k+1]  <= lowy_s[k] << 1;
      qx_s[k+1]    <= QW'({qx_s[k], gex});
      qy_s[k+1]    <= QW'({qy_s[k], gey});
    end
  end

  logic signed [FRAC_BITS+1:0] qxs, qys;

  always_comb begin
    qxs = {1'b0, qx_s[QW]};
    qys = {1'b0, qy_s[QW]};
  end

  // apply the signs of dx and dy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_s[QW];
    end
    out_carry <= carry_s[QW];
    out_dist  <= den_s[QW];
    out_nx    <= carry_s[QW].dx[cttr_pkg::DXT_W-1] ? -qxs : qxs;
    out_ny    <= carry_s[QW].dy[cttr_pkg::DXT_W-1] ? -qys : qys;
  end

endmodule

// ===== rtl/cttr_back.sv =====
// Back end: push-out along the normal, normal velocity removal, saturation.
module cttr_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  cttr_pkg::carry_t                    in_carry,
  input  logic [cttr_pkg::ROOT_W-1:0]         in_dist,
  input  logic signed [FRAC_BITS+1:0]         in_nx,
  input  logic signed [FRAC_BITS+1:0]         in_ny,
  output logic                                done,
  output logic                                hit,
  output logic signed [cttr_pkg::DATA_W-1:0]  new_position_x,
  output logic signed [cttr_pkg::DATA_W-1:0]  new_position_y,
  output logic signed [cttr_pkg::DATA_W-1:0]  new_velocity_x,
  output logic signed [cttr_pkg::DATA_W-1:0]  new_velocity_y
);

  localparam int NXW  = FRAC_BITS + 2;
  localparam int OVW  = cttr_pkg::RAD_W + 2;
  localparam int PMW  = NXW + OVW;
  localparam int VDW  = cttr_pkg::DATA_W + NXW;
  localparam int DOTW = cttr_pkg::DATA_W + 4;
  localparam int DVW  = DOTW + NXW;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // round to nearest, ties away from zero, back to FRAC_BITS fraction bits
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
    if (v >= 0) begin
      return (v + HALF) >>> FRAC_BITS;
    end else begin
      return -((-v + HALF) >>> FRAC_BITS);
    end
  endfunction

  // stage 1: products
  logic signed [OVW-1:0] ovl;
  logic                  s1_valid;
  cttr_pkg::carry_t      s1_carry;
  logic signed [PMW-1:0] s1_pmx, s1_pmy;
  logic signed [VDW-1:0] s1_vdx, s1_vdy;
  logic signed [NXW-1:0] s1_nx, s1_ny;

  always_comb begin
    ovl = signed'({2'b00, in_carry.r}) - signed'({1'b0, in_dist});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_carry <= in_carry;
    s1_nx    <= in_nx;
    s1_ny    <= in_ny;
    s1_pmx   <= in_nx * ovl;
    s1_pmy   <= in_ny * ovl;
    s1_vdx   <= in_carry.vx * in_nx;
    s1_vdy   <= in_carry.vy * in_ny;
  end

  // stage 2: new position, dot product
  logic signed [63:0] dot2, dotr;
  logic                               s2_valid, s2_cand, s2_neg;
  logic signed [cttr_pkg::DATA_W-1:0] s2_posx, s2_posy, s2_px, s2_py, s2_vx, s2_vy;
  logic signed [DOTW-1:0]             s2_dot;
  logic signed [NXW-1:0]              s2_nx, s2_ny;

  always_comb begin
    dot2 = 64'(s1_vdx) + 64'(s1_vdy);
    dotr = rnd(dot2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_cand <= s1_carry.cand;
    s2_px   <= s1_carry.px;
    s2_py   <= s1_carry.py;
    s2_vx   <= s1_carry.vx;
    s2_vy   <= s1_carry.vy;
    s2_nx   <= s1_nx;
    s2_ny   <= s1_ny;
    s2_posx <= cttr_pkg::sat32(64'(s1_carry.px) + rnd(64'(s1_pmx)));
    s2_posy <= cttr_pkg::sat32(64'(s1_carry.py) + rnd(64'(s1_pmy)));
    s2_neg  <= dot2 < 0;
    s2_dot  <= dotr[DOTW-1:0];
  end

  // stage 3: velocity correction products
  logic                               s3_valid, s3_cand, s3_neg;
  logic signed [cttr_pkg::DATA_W-1:0] s3_posx, s3_posy, s3_px, s3_py, s3_vx, s3_vy;
  logic signed [DVW-1:0]              s3_dvx, s3_dvy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_cand <= s2_cand;
    s3_neg  <= s2_neg;
    s3_posx <= s2_posx;
    s3_posy <= s2_posy;
    s3_px   <= s2_px;
    s3_py   <= s2_py;
    s3_vx   <= s2_vx;
    s3_vy   <= s2_vy;
    s3_dvx  <= s2_dot * s2_nx;
    s3_dvy  <= s2_dot * s2_ny;
  end

  // stage 4: output word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
    hit            <= s3_cand;
    new_position_x <= s3_cand ? s3_posx : s3_px;
    new_position_y <= s3_cand ? s3_posy : s3_py;
    new_velocity_x <= (s3_cand && s3_neg)
                      ? cttr_pkg::sat32(64'(s3_vx) - rnd(64'(s3_dvx))) : s3_vx;
    new_velocity_y <= (s3_cand && s3_neg)
                      ? cttr_pkg::sat32(64'(s3_vy) - rnd(64'(s3_dvy))) : s3_vy;
  end

endmodule

// ===== rtl/circle_tile_collision_resolve.sv =====
// Circle versus unit tile collision resolve, top level.
// Fully pipelined: one word is taken on every cycle that start is high (busy is
// always low), and its result appears with done at the end of the pipeline. It
// holds the 21-stage square root and the FRAC_BITS + 1 stage divider; the
// remaining stages are clamp, squares, compare, divider entry and sign, and four
// stages of products and rounding.
// The result is shown for one cycle only and cannot be held off.
module circle_tile_collision_resolve #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [cttr_pkg::DATA_W-1:0]  position_x,
  input  logic signed [cttr_pkg::DATA_W-1:0]  position_y,
  input  logic signed [cttr_pkg::DATA_W-1:0]  velocity_x,
  input  logic signed [cttr_pkg::DATA_W-1:0]  velocity_y,
  input  logic        [cttr_pkg::RAD_W-1:0]   circle_radius,
  input  logic signed [cttr_pkg::TILE_W-1:0]  tile_x,
  input  logic signed [cttr_pkg::TILE_W-1:0]  tile_y,
  output logic                                done,
  output logic                                hit,
  output logic signed [cttr_pkg::DATA_W-1:0]  new_position_x,
  output logic signed [cttr_pkg::DATA_W-1:0]  new_position_y,
  output logic signed [cttr_pkg::DATA_W-1:0]  new_velocity_x,
  output logic signed [cttr_pkg::DATA_W-1:0]  new_velocity_y
);

  localparam int LAT = 3 + cttr_pkg::ROOT_W + (FRAC_BITS + 3) + 4;

  assign busy = 1'b0;

  logic                          f_valid, s_valid, d_valid;
  cttr_pkg::carry_t              f_carry, s_carry, d_carry;
  logic [cttr_pkg::DSQ_W-1:0]    f_dsq;
  logic [cttr_pkg::ROOT_W-1:0]   s_root, d_dist;
  logic signed [FRAC_BITS+1:0]   d_nx, d_ny;

  cttr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .px        (position_x),
    .py        (position_y),
    .vx        (velocity_x),
    .vy        (velocity_y),
    .r         (circle_radius),
    .tx        (tile_x),
    .ty        (tile_y),
    .out_valid (f_valid),
    .out_carry (f_carry),
    .out_dsq   (f_dsq)
  );

  cttr_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_carry  (f_carry),
    .in_dsq    (f_dsq),
    .out_valid (s_valid),
    .out_carry (s_carry),
    .out_root  (s_root)
  );

  cttr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_carry  (s_carry),
    .in_root   (s_root),
    .out_valid (d_valid),
    .out_carry (d_carry),
    .out_dist  (d_dist),
    .out_nx    (d_nx),
    .out_ny    (d_ny)
  );

  cttr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (d_valid),
    .in_carry       (d_carry),
    .in_dist        (d_dist),
    .in_nx          (d_nx),
    .in_ny          (d_ny),
    .done           (done),
    .hit            (hit),
    .new_position_x (new_position_x),
    .new_position_y (new_position_y),
    .new_velocity_x (new_velocity_x),
    .new_velocity_y (new_velocity_y)
  );

  a_latency : assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("accepted word did not complete at the expected latency");

  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result word without a matching accepted word");

  a_miss_pass : assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> new_velocity_x == $past(velocity_x, LAT)
                     && new_position_y == $past(position_y, LAT))
    else $error("missed word was not passed through unchanged");

endmodule

// ===== dv/circle_tile_collision_resolve_tb.sv =====
// Self-checking testbench for the circle versus tile collision resolve pipeline.
module circle_tile_collision_resolve_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam longint unsigned EPS2 = ((64'd1 << (2 * FRAC)) + 64'd5000) / 64'd10000;
  localparam int LATENCY = 31 + FRAC;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [cttr_pkg::DATA_W-1:0] px, py, vx, vy;
    logic [cttr_pkg::RAD_W-1:0] r;
    logic signed [cttr_pkg::TILE_W-1:0] tx, ty;
  } probe_t;

  typedef struct {
    logic hit;
    logic signed [cttr_pkg::DATA_W-1:0] px, py, vx, vy;
  } resolve_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, hit;
  logic signed [cttr_pkg::DATA_W-1:0] position_x = '0, position_y = '0;
  logic signed [cttr_pkg::DATA_W-1:0] velocity_x = '0, velocity_y = '0;
  logic [cttr_pkg::RAD_W-1:0] circle_radius = '0;
  logic signed [cttr_pkg::TILE_W-1:0] tile_x = '0, tile_y = '0;
  logic signed [cttr_pkg::DATA_W-1:0] new_position_x, new_position_y;
  logic signed [cttr_pkg::DATA_W-1:0] new_velocity_x, new_velocity_y;

  probe_t pending_words[$];
  resolve_t expected_resolves[$];
  int errors = 0;
  int sent = 0;
  int hits_seen = 0;
  int send_idle_pct = 22;
  bit hold_send = 1'b0;
  longint cycles = 0;

  circle_tile_collision_resolve #(.FRAC_BITS(FRAC)) DUT (.*);

  always #5 clk = ~clk;

  function automatic longint round_frac(longint v);
    longint half = 64'sd1 << (FRAC - 1);
    if (v >= 0) return (v + half) >>> FRAC;
    return -(((-v) + half) >>> FRAC);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint div_frac(longint num, longint unsigned den);
    longint unsigned mag = num < 0 ? -num : num;
    longint unsigned q = ((mag << FRAC) + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_to_tile(longint p, longint lo);
    if (p < lo) return lo;
    if (p > lo + ONE) return lo + ONE;
    return p;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic resolve_t resolve_contact(probe_t w);
    resolve_t o;
    longint px = w.px, py = w.py, vx = w.vx, vy = w.vy;
    longint r = w.r;
    longint dx, dy, adx, ady, nx, ny, ovl, dot2, dotq;
    longint unsigned dsq, rsq, root_dist;
    dx = px - clamp_to_tile(px, longint'(w.tx) * ONE);
    dy = py - clamp_to_tile(py, longint'(w.ty) * ONE);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    o.hit = 1'b0;
    o.px = w.px; o.py = w.py; o.vx = w.vx; o.vy = w.vy;
    if (adx < r && ady < r) begin
      dsq = adx * adx + ady * ady;
      rsq = r * r;
      if (dsq < rsq && dsq > EPS2) begin
        root_dist = int_sqrt(dsq);
        if (root_dist == 0) root_dist = 1;
        nx = div_frac(dx, root_dist);
        ny = div_frac(dy, root_dist);
        ovl = r - longint'(root_dist);
        o.hit = 1'b1;
        o.px = clip32(px + round_frac(nx * ovl));
        o.py = clip32(py + round_frac(ny * ovl));
        dot2 = vx * nx + vy * ny;
        if (dot2 < 0) begin
          dotq = round_frac(dot2);
          o.vx = clip32(vx - round_frac(dotq * nx));
          o.vy = clip32(vy - round_frac(dotq * ny));
        end
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  function automatic logic [31:0] rand32();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  // Circle placed near a random tile, mostly overlapping an edge or a corner.
  function automatic probe_t near_tile();
    probe_t w;
    int tx = $urandom_range(0, 65535) - 32768;
    int ty = $urandom_range(0, 65535) - 32768;
    longint ox, oy;
    if ($urandom_range(0, 3) == 0) begin
      tx = $urandom_range(0, 8) - 4;
      ty = $urandom_range(0, 8) - 4;
    end
    w.tx = tx; w.ty = ty;
    w.r = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 2 * ONE);
    ox = longint'($urandom_range(0, 4 * ONE)) - ONE - ONE / 2;
    oy = longint'($urandom_range(0, 4 * ONE)) - ONE - ONE / 2;
    w.px = clip32(longint'(tx) * ONE + ox);
    w.py = clip32(longint'(ty) * ONE + oy);
    w.vx = $urandom_range(0, 7) == 0 ? rand32() : longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
    w.vy = $urandom_range(0, 7) == 0 ? rand32() : longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
    return w;
  endfunction

  function automatic probe_t make_probe(longint px, longint py, longint vx, longint vy,
                                        longint r, int tx, int ty);
    probe_t w;
    w.px = px; w.py = py; w.vx = vx; w.vy = vy; w.r = r; w.tx = tx; w.ty = ty;
    return w;
  endfunction

  // Driver: present a word at the falling edge, drop start when idling.
  always @(negedge clk) begin
    if (!rst && !busy && !hold_send && pending_words.size() > 0 &&
        $urandom_range(0, 99) >= send_idle_pct) begin
      probe_t w;
      w = pending_words.pop_front();
      position_x <= w.px; position_y <= w.py;
      velocity_x <= w.vx; velocity_y <= w.vy;
      circle_radius <= w.r; tile_x <= w.tx; tile_y <= w.ty;
      start <= 1'b1;
      expected_resolves.push_back(resolve_contact(w));
      sent++;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: compare each done word with the oldest expectation.
  always @(posedge clk) begin
    cycles++;
    if (!rst && done) begin
      if (expected_resolves.size() == 0) begin
        $display("Unexpected result word at cycle %0d", cycles);
        errors++;
      end else begin
        resolve_t e;
        e = expected_resolves.pop_front();
        if (hit) hits_seen++;
        if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
        if (new_position_x !== e.px) report_mismatch("new_position_x", new_position_x, e.px);
        if (new_position_y !== e.py) report_mismatch("new_position_y", new_position_y, e.py);
        if (new_velocity_x !== e.vx) report_mismatch("new_velocity_x", new_velocity_x, e.vx);
        if (new_velocity_y !== e.vy) report_mismatch("new_velocity_y", new_velocity_y, e.vy);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int phase;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed words: field extremes, edges, corners, inside, far away, saturation.
    pending_words.push_back(make_probe(0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_probe(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                       32'sh7fffffff, 20'hfffff, 16'sh7fff, 16'sh7fff));
    pending_words.push_back(make_probe(-64'sd2147483648, -64'sd2147483648,
                                       -64'sd2147483648, -64'sd2147483648, 20'hfffff,
                                       -32768, -32768));
    pending_words.push_back(make_probe(ONE / 2, ONE / 2, ONE, -ONE, ONE, 0, 0));
    pending_words.push_back(make_probe(-ONE / 4, ONE / 2, ONE, 0, ONE / 2, 0, 0));
    pending_words.push_back(make_probe(-ONE / 4, ONE / 2, -ONE, 0, ONE / 2, 0, 0));
    pending_words.push_back(make_probe(ONE + ONE / 4, ONE / 2, -ONE, ONE, ONE / 2, 0, 0));
    pending_words.push_back(make_probe(ONE / 2, -ONE / 3, 0, 3 * ONE, ONE / 2, 0, 0));
    pending_words.push_back(make_probe(ONE / 2, 2 * ONE - ONE / 8, 0, 0, ONE / 2, 0, 0));
    pending_words.push_back(make_probe(-ONE / 4, -ONE / 4, ONE, ONE, ONE / 2, 0, 0));
    pending_words.push_back(make_probe(ONE + ONE / 5, ONE + ONE / 5, -ONE, -2 * ONE,
                                       ONE / 2, 0, 0));
    pending_words.push_back(make_probe(-ONE / 4, ONE / 2, 0, ONE, ONE / 4, 0, 0));
    pending_words.push_back(make_probe(-2, ONE / 2, ONE, 0, ONE / 2, 0, 0));
    pending_words.push_back(make_probe(-ONE / 4, -ONE / 4, ONE, 0, 100, 0, 0));
    pending_words.push_back(make_probe(50 * ONE, 0, ONE, 0, 20'hfffff, 0, 0));
    pending_words.push_back(make_probe(32'sh7fff0000, 0, 32'sh7fffffff, 0,
                                       20'hfffff, 16'sh7ffe, 0));
    pending_words.push_back(make_probe(32'sh7ffff000, 0, -64'sd2147483648, 0,
                                       20'hfffff, 16'sh7ffe, 0));
    pending_words.push_back(make_probe(-64'sd2147483648, 0, 32'sh7fffffff, 0,
                                       20'hfffff, -32767, 0));
    pending_words.push_back(make_probe(-ONE / 2, -ONE / 2, 32'sh55555555, 32'shaaaaaaaa,
                                       20'h5a5a5, 16'sh5555, 16'shaaaa));

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 22 : (phase == 1 ? 81 : 0);
      repeat (phase == 1 ? 150 : 400) begin
        if ($urandom_range(0, 9) < 8) pending_words.push_back(near_tile());
        else pending_words.push_back(make_probe(rand32(), rand32(), rand32(), rand32(),
                                                $urandom, $urandom, $urandom));
      end
      wait (pending_words.size() == 0);
      // Hold the sender until the pipe drains once.
      if (phase == 0) begin
        hold_send = 1'b1;
        wait (expected_resolves.size() == 0);
        hold_send = 1'b0;
      end
    end

    fork
      wait (expected_resolves.size() == 0);
      begin
        repeat (LATENCY * 20) @(posedge clk);
      end
    join_any
    disable fork;
    repeat (LATENCY + 5) @(posedge clk);
    $display("Sent %0d words, %0d resolved as hits, %0d still outstanding",
             sent, hits_seen, expected_resolves.size());
    if (errors == 0 && expected_resolves.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== circle_tile_collision_resolve.f =====
rtl/cttr_pkg.sv
rtl/cttr_front.sv
rtl/cttr_sqrt.sv
rtl/cttr_div.sv
rtl/cttr_back.sv
rtl/circle_tile_collision_resolve.sv
dv/circle_tile_collision_resolve_tb.sv
